// File: design/dbwc_pkg.sv
// Shared constants, types and segment decode for the debounced button counter.
package dbwc_pkg;

  localparam int NUM_BUTTONS    = 8;
  localparam int STABLE_SAMPLES = 12;
  localparam int COUNT_LIMIT    = 1023;

  localparam int PIN_W   = 8;
  localparam int COUNT_W = 10;
  localparam int SEG_W   = 8;
  localparam int HIST_W  = STABLE_SAMPLES + 1;
  localparam int RUN_W   = $clog2(COUNT_LIMIT + 2 ** NUM_BUTTONS);
  localparam int SHOW_W  = $clog2(COUNT_LIMIT + 1);
  localparam int DEC_W   = 14;
  localparam int REM1_W  = 10;
  localparam int REM2_W  = 7;

  localparam logic [HIST_W-1:0] HIST_MATCH = {1'b1, {STABLE_SAMPLES{1'b0}}};
  localparam logic [SEG_W-1:0]  SEG_BLANK  = 8'hFF;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [PIN_W-1:0]   press_mask;
    logic               display_updated;
    logic [SHOW_W-1:0]  shown;
  } tick_res_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [PIN_W-1:0]   press_mask;
    logic               display_updated;
    digit_t             thousands;
    digit_t             hundreds;
    logic [REM2_W-1:0]  rem;
    logic               blank_tens;
    logic               blank_hundreds;
    logic               blank_thousands;
  } dec_res_t;

  function automatic logic [SEG_W-1:0] seg_code(input digit_t d);
    logic [SEG_W-1:0] code;
    unique case (d)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h98;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

// File: design/dbwc_tick_if.sv
// Handshake channels for raw pin samples and display results.
interface dbwc_tick_if;
  import dbwc_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIN_W-1:0] raw_pins;

  modport source (output valid, output raw_pins, input ready);
  modport sink (input valid, input raw_pins, output ready);
endinterface

interface dbwc_report_if;
  import dbwc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count;
  logic [PIN_W-1:0]   press_mask;
  logic               display_updated;
  logic [SEG_W-1:0]   seg_ones;
  logic [SEG_W-1:0]   seg_tens;
  logic [SEG_W-1:0]   seg_hundreds;
  logic [SEG_W-1:0]   seg_thousands;

  modport source (output valid, output count, output press_mask, output display_updated,
                  output seg_ones, output seg_tens, output seg_hundreds,
                  output seg_thousands, input ready);
  modport sink (input valid, input count, input press_mask, input display_updated,
                input seg_ones, input seg_tens, input seg_hundreds,
                input seg_thousands, output ready);
endinterface

// File: design/dbwc_front.sv
// Per-button sample histories, press detection and the running count.
module dbwc_front (
  input  logic                clk,
  input  logic                rst,
  dbwc_tick_if.sink           tick,
  output dbwc_pkg::tick_res_t res,
  output logic                res_valid,
  input  logic                res_ready
);
  import dbwc_pkg::*;

  logic [HIST_W-1:0]        hist      [NUM_BUTTONS];
  logic [HIST_W-1:0]        hist_next [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]   fire;
  logic [RUN_W-1:0]         running;
  logic [RUN_W-1:0]         running_next;
  logic [SHOW_W-1:0]        shown;
  logic [SHOW_W-1:0]        shown_next;
  logic [RUN_W-1:0]         total;
  logic                     wrap;
  logic [RUN_W+COUNT_W-1:0] cnt_ext;
  logic                     accept;

  assign tick.ready = !res_valid || res_ready;
  assign accept     = tick.valid && tick.ready;

  always_comb begin
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      if (HIST_W > 1) begin
        hist_next[k] = {hist[k][HIST_W-2:0], tick.raw_pins[k]};
      end else begin
        hist_next[k] = HIST_W'(tick.raw_pins[k]);
      end
      fire[k] = (hist_next[k] == HIST_MATCH);
    end
  end

  assign total        = running + RUN_W'(fire);
  assign wrap         = total > RUN_W'(COUNT_LIMIT);
  assign running_next = wrap ? RUN_W'(1) : total;
  assign shown_next   = wrap ? shown : total[SHOW_W-1:0];
  assign cnt_ext      = (RUN_W + COUNT_W)'(running_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_BUTTONS; k++) begin
        hist[k] <= '0;
      end
      running   <= '0;
      shown     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        for (int k = 0; k < NUM_BUTTONS; k++) begin
          hist[k] <= hist_next[k];
        end
        running <= running_next;
        shown   <= shown_next;
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.count           <= cnt_ext[COUNT_W-1:0];
      res.press_mask      <= PIN_W'(fire);
      res.display_updated <= !wrap;
      res.shown           <= shown_next;
    end
  end

endmodule

// File: design/dbwc_digits.sv
// Decimal split of the shown value and seven-segment output register.
module dbwc_digits (
  input  logic                clk,
  input  logic                rst,
  input  dbwc_pkg::tick_res_t res,
  input  logic                res_valid,
  output logic                res_ready,
  dbwc_report_if.source       report
);
  import dbwc_pkg::*;

  dec_res_t           s2;
  dec_res_t           s2_next;
  logic               s2_valid;
  logic               out_free;
  logic               s2_load;
  logic               out_load;
  logic [DEC_W-1:0]   v;
  logic [DEC_W-1:0]   rem1_wide;
  logic [REM1_W-1:0]  rem1;
  logic [REM1_W-1:0]  rem2_wide;
  digit_t             tens;
  logic [REM2_W-1:0]  ones_wide;

  assign out_free  = !report.valid || report.ready;
  assign res_ready = !s2_valid || out_free;
  assign s2_load   = res_valid && res_ready;
  assign out_load  = s2_valid && out_free;

  always_comb begin
    v         = DEC_W'(res.shown);
    rem1_wide = v;
    s2_next.thousands = '0;
    for (int d = 1; d <= 9; d++) begin
      if (v >= DEC_W'(d * 1000)) begin
        s2_next.thousands = digit_t'(d);
        rem1_wide         = v - DEC_W'(d * 1000);
      end
    end
    rem1      = rem1_wide[REM1_W-1:0];
    rem2_wide = rem1;
    s2_next.hundreds = '0;
    for (int d = 1; d <= 9; d++) begin
      if (rem1 >= REM1_W'(d * 100)) begin
        s2_next.hundreds = digit_t'(d);
        rem2_wide        = rem1 - REM1_W'(d * 100);
      end
    end
    s2_next.rem             = rem2_wide[REM2_W-1:0];
    s2_next.count           = res.count;
    s2_next.press_mask      = res.press_mask;
    s2_next.display_updated = res.display_updated;
    s2_next.blank_tens      = v < DEC_W'(10);
    s2_next.blank_hundreds  = v < DEC_W'(100);
    s2_next.blank_thousands = v < DEC_W'(1000);
  end

  always_comb begin
    tens      = '0;
    ones_wide = s2.rem;
    for (int d = 1; d <= 9; d++) begin
      if (s2.rem >= REM2_W'(d * 10)) begin
        tens      = digit_t'(d);
        ones_wide = s2.rem - REM2_W'(d * 10);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      report.valid <= 1'b0;
    end else begin
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (out_free) begin
        s2_valid <= 1'b0;
      end
      if (out_load) begin
        report.valid <= 1'b1;
      end else if (report.ready) begin
        report.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2 <= s2_next;
    end
    if (out_load) begin
      report.count           <= s2.count;
      report.press_mask      <= s2.press_mask;
      report.display_updated <= s2.display_updated;
      report.seg_ones        <= seg_code(digit_t'(ones_wide));
      report.seg_tens        <= s2.blank_tens ? SEG_BLANK : seg_code(tens);
      report.seg_hundreds    <= s2.blank_hundreds ? SEG_BLANK : seg_code(s2.hundreds);
      report.seg_thousands   <= s2.blank_thousands ? SEG_BLANK : seg_code(s2.thousands);
    end
  end

endmodule

// File: design/debounced_button_weighted_counter.sv
// Debounced button weighted counter with four-digit seven-segment output.
// A sample moves through three registered stages: count, decimal split and output.
// Throughput: one sample per cycle while report.ready is held high, else it stalls.
// Reset: clears all button histories, the running and shown counts, and every stage valid.
module debounced_button_weighted_counter (
  input logic           clk,
  input logic           rst,
  dbwc_tick_if.sink     tick,
  dbwc_report_if.source report
);
  import dbwc_pkg::*;

  tick_res_t res;
  logic      res_valid;
  logic      res_ready;

  dbwc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  dbwc_digits u_digits (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .report    (report)
  );

endmodule

// File: tb/sv/debounced_button_weighted_counter_tb.sv
// Self-checking bench for the debounced button counter: debounce, weighted count, wrap, display.
`timescale 1ns / 100ps

module debounced_button_weighted_counter_tb;
  import dbwc_pkg::*;

  localparam int RANDOM_TICKS = 1650;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic [PIN_W-1:0]   press_mask;
    logic               display_updated;
    logic [SEG_W-1:0]   seg_ones;
    logic [SEG_W-1:0]   seg_tens;
    logic [SEG_W-1:0]   seg_hundreds;
    logic [SEG_W-1:0]   seg_thousands;
  } display_report_t;

  logic clk;
  logic rst;

  dbwc_tick_if   tick_ch ();
  dbwc_report_if report_ch ();

  debounced_button_weighted_counter dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .report (report_ch)
  );

  logic [PIN_W-1:0] pin_samples [$];
  display_report_t  pending_reports [$];
  logic [HIST_W-1:0] button_hist [NUM_BUTTONS];
  logic [RUN_W-1:0]  running_total;
  logic [SHOW_W-1:0] shown_total;
  int stimulus_total;
  int sent_ticks;
  int mismatch_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("debounced_button_weighted_counter: mismatch");
    $finish;
  end

  function automatic logic [SEG_W-1:0] digit_segments(input int d);
    case (d)
      0:       return 8'hC0;
      1:       return 8'hF9;
      2:       return 8'hA4;
      3:       return 8'hB0;
      4:       return 8'h99;
      5:       return 8'h92;
      6:       return 8'h82;
      7:       return 8'hF8;
      8:       return 8'h80;
      default: return 8'h98;
    endcase
  endfunction

  function automatic display_report_t advance_counter(input logic [PIN_W-1:0] pins);
    display_report_t r;
    logic [RUN_W-1:0] total;
    int v;
    r.press_mask = '0;
    total = running_total;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      button_hist[k] = {button_hist[k][HIST_W-2:0], pins[k]};
      if (button_hist[k] == HIST_MATCH) begin
        r.press_mask[k] = 1'b1;
        total = total + (RUN_W'(1) << k);
      end
    end
    if (total > COUNT_LIMIT) begin
      total = RUN_W'(1);
      r.display_updated = 1'b0;
    end else begin
      shown_total = total[SHOW_W-1:0];
      r.display_updated = 1'b1;
    end
    running_total = total;
    r.count = total[COUNT_W-1:0];
    v = shown_total;
    r.seg_ones      = digit_segments(v % 10);
    r.seg_tens      = (v > 9)   ? digit_segments((v / 10) % 10)   : SEG_BLANK;
    r.seg_hundreds  = (v > 99)  ? digit_segments((v / 100) % 10)  : SEG_BLANK;
    r.seg_thousands = (v > 999) ? digit_segments((v / 1000) % 10) : SEG_BLANK;
    return r;
  endfunction

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t %s expected %0h actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic int send_idle_pct();
    if (sent_ticks * 3 < stimulus_total) return 24;
    if (sent_ticks * 3 < stimulus_total * 2) return 54;
    return 0;
  endfunction

  function automatic int recv_stall_pct();
    if (sent_ticks * 3 < stimulus_total) return 54;
    if (sent_ticks * 3 < stimulus_total * 2) return 24;
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else if (!tick_ch.valid || tick_ch.ready) begin
      if (pin_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        tick_ch.valid    <= 1'b1;
        tick_ch.raw_pins <= pin_samples.pop_front();
        sent_ticks++;
      end else begin
        tick_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      report_ch.ready <= 1'b0;
    end else begin
      report_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct());
    end
  end

  always @(posedge clk) begin
    display_report_t want;
    if (!rst) begin
      if (tick_ch.valid && tick_ch.ready) begin
        pending_reports.push_back(advance_counter(tick_ch.raw_pins));
      end
      if (report_ch.valid && report_ch.ready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t unexpected transfer: expected none actual count %0h", $time,
                   report_ch.count);
          mismatch_count++;
        end else begin
          want = pending_reports.pop_front();
          compare_field("count", want.count, report_ch.count);
          compare_field("press_mask", want.press_mask, report_ch.press_mask);
          compare_field("display_updated", want.display_updated, report_ch.display_updated);
          compare_field("seg_ones", want.seg_ones, report_ch.seg_ones);
          compare_field("seg_tens", want.seg_tens, report_ch.seg_tens);
          compare_field("seg_hundreds", want.seg_hundreds, report_ch.seg_hundreds);
          compare_field("seg_thousands", want.seg_thousands, report_ch.seg_thousands);
        end
      end
    end
  end

  initial begin
    logic [PIN_W-1:0] pins;
    bit level [NUM_BUTTONS];
    int run_left [NUM_BUTTONS];
    rst = 1'b1;
    tick_ch.valid = 1'b0;
    tick_ch.raw_pins = '0;
    report_ch.ready = 1'b0;
    cycle_count = 0;
    sent_ticks = 0;
    mismatch_count = 0;
    running_total = '0;
    shown_total = '0;
    foreach (button_hist[k]) button_hist[k] = '0;

    // hold every button pressed from reset: no press may fire without a release first
    repeat (12) pin_samples.push_back(8'h00);
    // release all, then hold pressed long enough for every button to fire
    pin_samples.push_back(8'hFF);
    repeat (12) pin_samples.push_back(8'h00);

    foreach (level[k]) begin
      level[k] = 1'b1;
      run_left[k] = $urandom_range(0, 5);
    end
    for (int i = 0; i < RANDOM_TICKS; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        pins = PIN_W'($urandom_range(0, 255));
      end else begin
        for (int k = 0; k < NUM_BUTTONS; k++) begin
          if (run_left[k] == 0) begin
            level[k] = !level[k];
            if (level[k])
              run_left[k] = $urandom_range(1, 6);
            else if ($urandom_range(0, 3) == 0)
              run_left[k] = $urandom_range(1, 11);
            else
              run_left[k] = $urandom_range(12, 24);
          end
          run_left[k]--;
          pins[k] = level[k] ^ ($urandom_range(0, 49) == 0);
        end
      end
      pin_samples.push_back(pins);
    end
    stimulus_total = pin_samples.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pin_samples.size() > 0 || tick_ch.valid || pending_reports.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_reports.size() > 0) begin
      $display("%0t missing transfer: expected %0d more actual 0", $time,
               pending_reports.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("debounced_button_weighted_counter: match");
    end else begin
      $display("debounced_button_weighted_counter: mismatch");
    end
    $finish;
  end

endmodule
